// File: hw/rtl/spq_pkg.sv
// Shared types and default sizes for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

   localparam int SPQ_DEPTH       = 16;
   localparam int SPQ_VALUE_WIDTH = 32;
   localparam int SPQ_PRIO_WIDTH  = 16;

   typedef enum logic [1:0] {
      MODE_INSERT   = 2'd0,
      MODE_DEQUEUE  = 2'd1,
      MODE_INCREASE = 2'd2,
      MODE_DECREASE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_REMOVE,
      CELL_INSERT,
      CELL_SET_HEAD
   } cell_action_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_action_type action;
      logic            rm_head_only;
      logic            rm_any_pos;
      logic            ins_put;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SECOND,
      ST_REPORT
   } state_type;

endpackage

// File: hw/rtl/spq_cell.sv
// One slot of the sorted row: holds a value and a priority and trades them
// with its neighbours on remove and insert passes. Depends on spq_pkg.
module spq_cell #(
   parameter int INDEX       = 0,
   parameter int DEPTH       = spq_pkg::SPQ_DEPTH,
   parameter int VALUE_WIDTH = spq_pkg::SPQ_VALUE_WIDTH,
   parameter int PRIO_WIDTH  = spq_pkg::SPQ_PRIO_WIDTH
) (
   input  logic                         clock,
   input  spq_pkg::cell_cmd_type        cmd,
   input  logic [VALUE_WIDTH-1:0]       cmd_value,
   input  logic [PRIO_WIDTH-1:0]        cmd_prio,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   input  logic [VALUE_WIDTH-1:0]       left_value,
   input  logic [PRIO_WIDTH-1:0]        left_prio,
   input  logic [VALUE_WIDTH-1:0]       right_value,
   input  logic [PRIO_WIDTH-1:0]        right_prio,
   input  logic                         seen_in,
   output logic                         seen_out,
   output logic [VALUE_WIDTH-1:0]       value,
   output logic [PRIO_WIDTH-1:0]        prio
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] IDX = CW'(INDEX);
   localparam bit IS_HEAD = (INDEX == 0);
   localparam bit IS_LAST = (INDEX == DEPTH - 1);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PRIO_WIDTH-1:0]  prio_ff, prio_in;
   logic                   mark_ff, mark_in;
   logic                   valid, match, le, lt, rm_hit, ins_hit;

   always_comb begin
      valid = IDX < count;
      match = valid && (value_ff == cmd_value);
      le    = prio_ff <= cmd_prio;
      lt    = prio_ff < cmd_prio;

      if (cmd.rm_head_only) begin
         rm_hit = valid && IS_HEAD;
      end else begin
         rm_hit = match && (!IS_HEAD || cmd.rm_any_pos);
      end

      // A new entry only displaces the head when it is strictly more urgent.
      if (cmd.ins_put && IS_HEAD) begin
         ins_hit = valid && lt;
      end else begin
         ins_hit = valid && (cmd.ins_put || mark_ff) && le;
      end
   end

   always_comb begin
      seen_out = seen_in;
      value_in = value_ff;
      prio_in  = prio_ff;
      mark_in  = mark_ff;
      unique case (cmd.action)
         CELL_HOLD: begin
         end
         CELL_REMOVE: begin
            // Every slot from the removed one onwards pulls from its right.
            seen_out = seen_in || rm_hit;
            mark_in  = seen_in || rm_hit;
            if ((seen_in || rm_hit) && !IS_LAST) begin
               value_in = right_value;
               prio_in  = right_prio;
            end
         end
         CELL_INSERT: begin
            seen_out = seen_in || ins_hit;
            if (!seen_in && (ins_hit || IDX == count)) begin
               value_in = cmd_value;
               prio_in  = cmd_prio;
            end else if (seen_in && IDX <= count) begin
               value_in = left_value;
               prio_in  = left_prio;
            end
         end
         CELL_SET_HEAD: begin
            if (IS_HEAD) begin
               prio_in = cmd_prio;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
      mark_ff  <= mark_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

// File: hw/rtl/spq_ctrl.sv
// Sequencer of the sorted priority queue: captures a word, drives the cell
// row through its remove and insert passes and keeps the entry count.
// Depends on spq_pkg.
module spq_ctrl #(
   parameter int DEPTH       = spq_pkg::SPQ_DEPTH,
   parameter int VALUE_WIDTH = spq_pkg::SPQ_VALUE_WIDTH,
   parameter int PRIO_WIDTH  = spq_pkg::SPQ_PRIO_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  spq_pkg::mode_type            req_mode,
   input  logic [VALUE_WIDTH-1:0]       req_item_value,
   input  logic [PRIO_WIDTH-1:0]        req_item_priority,
   input  logic [VALUE_WIDTH-1:0]       head_value,
   input  logic                         found,
   input  logic                         out_free,
   output spq_pkg::cell_cmd_type        cmd,
   output logic [VALUE_WIDTH-1:0]       cmd_value,
   output logic [PRIO_WIDTH-1:0]        cmd_prio,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output logic                         report,
   output logic                         dropped
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [PRIO_WIDTH-1:0]  prio_ff, prio_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   dropped_ff, dropped_in;
   logic                   full, head_match;

   assign full       = count_ff == FULL_COUNT;
   assign head_match = (count_ff != '0) && (head_value == value_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if ((mode_ff == MODE_INCREASE && count_ff != '0 && !head_match) ||
                (mode_ff == MODE_DECREASE && found)) begin
               state_in = ST_SECOND;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_SECOND: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      cmd.action       = CELL_HOLD;
      cmd.rm_head_only = 1'b0;
      cmd.rm_any_pos   = 1'b0;
      cmd.ins_put      = 1'b0;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      mode_in    = mode_ff;
      value_in   = value_ff;
      prio_in    = prio_ff;
      req_ready  = state_ff == ST_IDLE;
      report     = (state_ff == ST_REPORT) && out_free;

      if (req_ready && req_valid) begin
         mode_in    = req_mode;
         value_in   = req_item_value;
         prio_in    = req_item_priority;
         dropped_in = 1'b0;
      end

      unique case (state_ff)
         ST_FIRST: begin
            unique case (mode_ff)
               MODE_INSERT: begin
                  if (full) begin
                     dropped_in = 1'b1;
                  end else begin
                     cmd.action  = CELL_INSERT;
                     cmd.ins_put = 1'b1;
                     count_in    = count_ff + CW'(1);
                  end
               end
               MODE_DEQUEUE: begin
                  cmd.action       = CELL_REMOVE;
                  cmd.rm_head_only = 1'b1;
                  if (found) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               MODE_INCREASE: begin
                  if (head_match) begin
                     cmd.action = CELL_SET_HEAD;
                  end else if (count_ff != '0) begin
                     cmd.action = CELL_REMOVE;
                     if (found) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               MODE_DECREASE: begin
                  cmd.action     = CELL_REMOVE;
                  cmd.rm_any_pos = 1'b1;
                  if (found) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SECOND: begin
            // An increase reinserts like a new entry; a decrease reinserts from the slot it was taken out of onwards.
            if (full) begin
               dropped_in = 1'b1;
            end else begin
               cmd.action  = CELL_INSERT;
               cmd.ins_put = mode_ff == MODE_INCREASE;
               count_in    = count_ff + CW'(1);
            end
         end
         ST_IDLE, ST_REPORT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign cmd_value = value_ff;
   assign cmd_prio  = prio_ff;
   assign count     = count_ff;
   assign dropped   = dropped_ff;

endmodule

// File: hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue built as a row of DEPTH cells and a small sequencer.
// rsp_valid is registered: it rises after the first pass, and after the reinsert pass when a
// key change needs one, once the report state finds the result register free.
// A new word is accepted only in the idle state, so each word's passes over the cell row
// and its report finish before the next word is taken.
// Reset clears the count, the sequencer and the result valid flag; slots and result data are not cleared.
module sorted_priority_queue_core #(
   parameter int DEPTH       = spq_pkg::SPQ_DEPTH,
   parameter int VALUE_WIDTH = spq_pkg::SPQ_VALUE_WIDTH,
   parameter int PRIO_WIDTH  = spq_pkg::SPQ_PRIO_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  spq_pkg::mode_type            req_mode,
   input  logic [VALUE_WIDTH-1:0]       req_item_value,
   input  logic [PRIO_WIDTH-1:0]        req_item_priority,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [VALUE_WIDTH-1:0]       rsp_head_value,
   output logic [PRIO_WIDTH-1:0]        rsp_head_priority,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_entry_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_dropped
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   cell_cmd_type           cmd;
   logic [VALUE_WIDTH-1:0] cmd_value;
   logic [PRIO_WIDTH-1:0]  cmd_prio;
   logic [CW-1:0]          count;
   logic                   report, dropped, out_free;
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [PRIO_WIDTH-1:0]  cell_prio  [DEPTH];
   logic [DEPTH:0]         seen;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] head_value_ff;
   logic [PRIO_WIDTH-1:0]  head_prio_ff;
   logic [CW-1:0]          count_ff;
   logic                   empty_ff, dropped_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign seen[0]  = 1'b0;

   spq_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .PRIO_WIDTH  (PRIO_WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .head_value        (cell_value[0]),
      .found             (seen[DEPTH]),
      .out_free          (out_free),
      .cmd               (cmd),
      .cmd_value         (cmd_value),
      .cmd_prio          (cmd_prio),
      .count             (count),
      .report            (report),
      .dropped           (dropped)
   );

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      spq_cell #(
         .INDEX       (j),
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .PRIO_WIDTH  (PRIO_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cmd_value   (cmd_value),
         .cmd_prio    (cmd_prio),
         .count       (count),
         .left_value  (cell_value[(j == 0) ? 0 : j - 1]),
         .left_prio   (cell_prio[(j == 0) ? 0 : j - 1]),
         .right_value (cell_value[(j == DEPTH - 1) ? j : j + 1]),
         .right_prio  (cell_prio[(j == DEPTH - 1) ? j : j + 1]),
         .seen_in     (seen[j]),
         .seen_out    (seen[j + 1]),
         .value       (cell_value[j]),
         .prio        (cell_prio[j])
      );
   end

   // Result register: loaded from the settled row once the passes are done.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         head_value_ff <= (count != '0) ? cell_value[0] : '0;
         head_prio_ff  <= (count != '0) ? cell_prio[0] : '0;
         count_ff      <= count;
         empty_ff      <= count == '0;
         dropped_ff    <= dropped;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_value    = head_value_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_is_empty      = empty_ff;
   assign rsp_dropped       = dropped_ff;

`ifndef SYNTHESIS
   // The entry count moves by at most one slot per cycle.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count == $past(count)) || (count == $past(count) + 1'b1) ||
      (count + 1'b1 == $past(count)))
      else $error("entry count jumped by more than one");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_entry_count == CW'(DEPTH)))
      else $error("word dropped while the store had room");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new word taken while the row was still busy");
`endif

endmodule

// File: dv/sorted_priority_queue_core_test.sv
// Self-checking testbench for sorted_priority_queue_core: directed and random words
// checked against a behavioural shadow of the queue under varying back-pressure.
// Depends on spq_pkg and the sorted_priority_queue_core RTL only.
module sorted_priority_queue_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int COUNT_WIDTH = $clog2(SPQ_DEPTH + 1);
   localparam int QUIET_LIMIT = 3000;

   typedef struct packed {
      logic [SPQ_VALUE_WIDTH-1:0] head_value;
      logic [SPQ_PRIO_WIDTH-1:0]  head_priority;
      logic [COUNT_WIDTH-1:0]     entry_count;
      logic                       is_empty;
      logic                       dropped;
   } head_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   mode_type                   req_mode = MODE_INSERT;
   logic [SPQ_VALUE_WIDTH-1:0] req_item_value = '0;
   logic [SPQ_PRIO_WIDTH-1:0]  req_item_priority = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [SPQ_VALUE_WIDTH-1:0] rsp_head_value;
   logic [SPQ_PRIO_WIDTH-1:0]  rsp_head_priority;
   logic [COUNT_WIDTH-1:0]     rsp_entry_count;
   logic                       rsp_is_empty;
   logic                       rsp_dropped;

   // Shadow copy of the queue contents, slot 0 being the head.
   logic [SPQ_VALUE_WIDTH-1:0] shadow_value [SPQ_DEPTH];
   logic [SPQ_PRIO_WIDTH-1:0]  shadow_priority [SPQ_DEPTH];
   int                         shadow_count = 0;

   head_report_type head_report_q [$];
   head_report_type seen_report;
   head_report_type want_report;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int error_count = 0;

   sorted_priority_queue_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_head_value    (rsp_head_value),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_dropped       (rsp_dropped)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void shadow_remove(int pos);
      if (pos >= shadow_count) return;
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_value[i]    = shadow_value[i + 1];
         shadow_priority[i] = shadow_priority[i + 1];
      end
      shadow_count--;
   endfunction

   // Returns 1 when the store is full and the entry is discarded.
   function automatic bit shadow_put(logic [SPQ_VALUE_WIDTH-1:0] v,
                                     logic [SPQ_PRIO_WIDTH-1:0] p);
      int pos;
      if (shadow_count >= SPQ_DEPTH) return 1'b1;
      // The walk starts after the head, so an equal head keeps its place.
      if (shadow_count == 0 || shadow_priority[0] < p) begin
         pos = 0;
      end else begin
         pos = 1;
         while (pos < shadow_count && shadow_priority[pos] > p) pos++;
      end
      for (int i = shadow_count; i > pos; i--) begin
         shadow_value[i]    = shadow_value[i - 1];
         shadow_priority[i] = shadow_priority[i - 1];
      end
      shadow_value[pos]    = v;
      shadow_priority[pos] = p;
      shadow_count++;
      return 1'b0;
   endfunction

   function automatic void advance_shadow_queue(mode_type m, logic [SPQ_VALUE_WIDTH-1:0] v,
                                                logic [SPQ_PRIO_WIDTH-1:0] p);
      bit           drop;
      int           i;
      logic [SPQ_VALUE_WIDTH-1:0] tv;
      logic [SPQ_PRIO_WIDTH-1:0]  tp;
      head_report_type r;
      drop = 1'b0;
      case (m)
         MODE_INSERT: begin
            drop = shadow_put(v, p);
         end
         MODE_DEQUEUE: begin
            shadow_remove(0);
         end
         MODE_INCREASE: begin
            if (shadow_count > 0) begin
               if (shadow_value[0] == v) begin
                  shadow_priority[0] = p;
               end else begin
                  i = 1;
                  while (i < shadow_count && shadow_value[i] != v) i++;
                  if (i < shadow_count) shadow_remove(i);
                  drop = shadow_put(v, p);
               end
            end
         end
         default: begin
            i = 0;
            while (i < shadow_count && shadow_value[i] != v) i++;
            if (i < shadow_count) begin
               shadow_priority[i] = p;
               while (i + 1 < shadow_count && shadow_priority[i + 1] > p) begin
                  tv = shadow_value[i];
                  tp = shadow_priority[i];
                  shadow_value[i]        = shadow_value[i + 1];
                  shadow_priority[i]     = shadow_priority[i + 1];
                  shadow_value[i + 1]    = tv;
                  shadow_priority[i + 1] = tp;
                  i++;
               end
            end
         end
      endcase
      r.head_value    = (shadow_count > 0) ? shadow_value[0] : '0;
      r.head_priority = (shadow_count > 0) ? shadow_priority[0] : '0;
      r.entry_count   = shadow_count[COUNT_WIDTH-1:0];
      r.is_empty      = (shadow_count == 0);
      r.dropped       = drop;
      head_report_q.push_back(r);
   endfunction

   // Offers one word, holding it until accepted, then records its expected report.
   task automatic send_word(mode_type m, logic [SPQ_VALUE_WIDTH-1:0] v,
                            logic [SPQ_PRIO_WIDTH-1:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_item_value    <= v;
      req_item_priority <= p;
      do @(posedge clock); while (!req_ready);
      advance_shadow_queue(m, v, p);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (head_report_q.size() != 0) @(posedge clock);
   endtask

   // Mostly values already held, so that key changes find their entry.
   function automatic logic [SPQ_VALUE_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (shadow_count > 0 && r < 55) return shadow_value[$urandom_range(shadow_count - 1)];
      if (r < 70) return $urandom_range(7);
      if (r < 75) return 32'hFFFF_FFFF - $urandom_range(3);
      return $urandom;
   endfunction

   // Narrow ranges give plenty of equal priorities.
   function automatic logic [SPQ_PRIO_WIDTH-1:0] pick_priority();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 16'($urandom_range(3));
      if (r < 40) return 16'hFFFF - 16'($urandom_range(1));
      if (r < 55) return 16'($urandom_range(15) << 12);
      return 16'($urandom_range(16'hFFFF));
   endfunction

   task automatic random_words(int count, int insert_pct);
      int       r;
      mode_type m;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < insert_pct) m = MODE_INSERT;
         else if (r < insert_pct + (100 - insert_pct) / 3) m = MODE_DEQUEUE;
         else if (r < insert_pct + 2 * (100 - insert_pct) / 3) m = MODE_INCREASE;
         else m = MODE_DECREASE;
         send_word(m, pick_value(), pick_priority());
      end
   endtask

   // Alternates filling and draining so the queue swings between empty and full.
   task automatic random_phase(int sender_pct, int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int chunk = 0; chunk < 5; chunk++) begin
         random_words(45, (chunk % 2 == 0) ? 65 : 20);
      end
   endtask

   task automatic test_empty_and_ordering();
      send_idle_pct = 13;
      recv_idle_pct = 59;
      send_word(MODE_DEQUEUE,  32'h0000_0000, 16'h0000);
      send_word(MODE_INCREASE, 32'h1234_5678, 16'h0010);
      send_word(MODE_DECREASE, 32'h1234_5678, 16'h0010);
      send_word(MODE_INSERT,   32'h0000_0000, 16'h0000);
      send_word(MODE_INSERT,   32'hFFFF_FFFF, 16'hFFFF);
      send_word(MODE_INSERT,   32'h5555_5555, 16'hFFFF);
      send_word(MODE_INSERT,   32'hAAAA_AAAA, 16'h8000);
      send_word(MODE_INSERT,   32'h1234_5678, 16'h7FFF);
      // Lowering the head through increase key leaves the store unsorted.
      send_word(MODE_INCREASE, 32'hFFFF_FFFF, 16'h0001);
      send_word(MODE_INSERT,   32'h0BAD_F00D, 16'h4000);
      send_word(MODE_INCREASE, 32'hAAAA_AAAA, 16'hFFFF);
      send_word(MODE_INCREASE, 32'hDEAD_BEEF, 16'h0100);
      send_word(MODE_DECREASE, 32'h5555_5555, 16'h0000);
      send_word(MODE_DECREASE, 32'h0F0F_0F0F, 16'h0000);
      send_word(MODE_INSERT,   32'hAAAA_AAAA, 16'h0003);
      send_word(MODE_DECREASE, 32'hAAAA_AAAA, 16'h0002);
      send_word(MODE_INCREASE, 32'hAAAA_AAAA, 16'h9000);
      send_word(MODE_DECREASE, shadow_value[0], 16'h0000);
      send_word(MODE_DEQUEUE,  32'h0000_0000, 16'h0000);
      send_word(MODE_DECREASE, 32'h1234_5678, 16'hFFFF);
   endtask

   task automatic test_full_store();
      send_idle_pct = 13;
      recv_idle_pct = 59;
      while (shadow_count < SPQ_DEPTH) send_word(MODE_INSERT, $urandom, pick_priority());
      send_word(MODE_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(MODE_INSERT, 32'h0000_0000, 16'h0000);
      // An absent value on increase key is inserted, and so dropped when full.
      send_word(MODE_INCREASE, 32'hC0DE_0001, 16'h0200);
      send_word(MODE_INCREASE, shadow_value[SPQ_DEPTH - 1], 16'hFFFE);
      while (shadow_count > 0) begin
         send_word(MODE_DEQUEUE, $urandom, 16'($urandom_range(16'hFFFF)));
      end
      send_word(MODE_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   task automatic test_slow_receiver();
      random_phase(13, 59);
   endtask

   task automatic test_slow_sender();
      random_phase(59, 13);
   endtask

   task automatic test_back_to_back();
      random_phase(0, 0);
   endtask

   // The receiver stops for a long stretch while words keep coming, so the
   // block fills and stalls its input; then the sender waits for the backlog.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 300;
      random_words(40, 50);
      pause_until_drained();
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_report = '{rsp_head_value, rsp_head_priority, rsp_entry_count,
                         rsp_is_empty, rsp_dropped};
         if (head_report_q.size() == 0) begin
            $error("unexpected result word: head_value %h count %0d",
                   rsp_head_value, rsp_entry_count);
            error_count++;
         end else begin
            want_report = head_report_q.pop_front();
            if (seen_report.head_value !== want_report.head_value) begin
               $error("head_value: expected %h, got %h",
                      want_report.head_value, seen_report.head_value);
               error_count++;
            end
            if (seen_report.head_priority !== want_report.head_priority) begin
               $error("head_priority: expected %h, got %h",
                      want_report.head_priority, seen_report.head_priority);
               error_count++;
            end
            if (seen_report.entry_count !== want_report.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want_report.entry_count, seen_report.entry_count);
               error_count++;
            end
            if (seen_report.is_empty !== want_report.is_empty) begin
               $error("is_empty: expected %b, got %b",
                      want_report.is_empty, seen_report.is_empty);
               error_count++;
            end
            if (seen_report.dropped !== want_report.dropped) begin
               $error("dropped: expected %b, got %b",
                      want_report.dropped, seen_report.dropped);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("sorted_priority_queue_core_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_ordering();
      test_full_store();
      test_slow_receiver();
      test_slow_sender();
      test_back_to_back();
      test_backpressure();
      pause_until_drained();
      repeat (8) @(posedge clock);
      if (head_report_q.size() != 0) begin
         $error("%0d result words never arrived", head_report_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("sorted_priority_queue_core_test: done, clean");
      end else begin
         $display("sorted_priority_queue_core_test: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue_core.sv
dv/sorted_priority_queue_core_test.sv
